// ===== hdl/mpa_pkg.sv =====
// Shared types and constants of the max pooling block with argmax.
// Used by max_pool_with_argmax_top; depends on nothing else.
package mpa_pkg;

  localparam int unsigned MAX_WIDTH    = 256;
  localparam int unsigned MAX_CHANNELS = 64;
  localparam int unsigned VALUE_BITS   = 16;

  localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
  localparam int unsigned CH_BITS    = $clog2(MAX_CHANNELS);
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned ADDR_BITS  = $clog2(STORE_DEPTH);

  localparam int unsigned POS_BITS   = 8;
  localparam int unsigned PHASE_BITS = 4;
  localparam int unsigned ARG_BITS   = 2 * PHASE_BITS;
  localparam int unsigned IMG_BITS   = 16;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned OUT_DATA_BITS = 48;

  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BATCH_COUNT   = 3'd4;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [ARG_BITS-1:0]          argmax;
  } entry_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] sample;
    logic                         first;
    logic                         fits;
    logic                         prod;
    logic [ARG_BITS-1:0]          argmax;
    logic [ADDR_BITS-1:0]         addr;
    logic [POS_BITS-1:0]          pcol;
    logic [POS_BITS-1:0]          prow;
    logic [CH_BITS-1:0]           chan;
    logic                         last_img;
    logic                         last_batch;
  } stage_t;

  typedef struct packed {
    entry_t               ent;
    logic [POS_BITS-1:0]  pcol;
    logic [POS_BITS-1:0]  prow;
    logic [CH_BITS-1:0]   chan;
    logic                 last_img;
    logic                 last_batch;
  } result_t;

endpackage

// ===== hdl/max_pool_with_argmax_top.sv =====
// Streaming 2-D max pooling with argmax over non-overlapping square windows.
// Samples enter the stage register, results the output register; throughput is
// one word per clock unless output stalls: the store has one read and one write
// port, and a write-back register bypasses the entry written in the cycle of
// a read. Reset is asynchronous and active low; it clears all counters and
// sets the registers to their defaults. The store holds no reset state.
module max_pool_with_argmax_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mpa_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [mpa_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_value [15:0]
  input  logic [mpa_pkg::VALUE_BITS-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // max_value [15:0], window_argmax [23:16], pool_column [31:24],
  // pool_row [39:32], channel_index [45:40], zeros [47:46]
  output logic [mpa_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // last_of_image
  output logic                               m_axis_tlast,
  // last_of_batch
  output logic                               m_axis_tuser
);

  localparam int unsigned PB = mpa_pkg::POS_BITS;
  localparam int unsigned HB = mpa_pkg::PHASE_BITS;
  localparam int unsigned CB = mpa_pkg::CH_BITS;
  localparam int unsigned IB = mpa_pkg::IMG_BITS;

  // Configuration, stored already clamped to the legal range.
  logic [PB:0]   width_q, height_q;
  logic [CB:0]   chans_q;
  logic [HB:0]   win_q;
  logic [IB-1:0] batch_q;

  logic [PB-1:0] col_q, row_q, pcol_q, prow_q;
  logic [CB-1:0] chan_q;
  logic [HB-1:0] cph_q, rph_q;
  logic [IB-1:0] img_q;

  logic                 s1_valid_q, out_valid_q, lw_valid_q;
  mpa_pkg::stage_t      s1_q, s0;
  mpa_pkg::result_t     out_q;
  mpa_pkg::entry_t      rd_q, lw_data_q, old_ent, new_ent;
  logic [mpa_pkg::ADDR_BITS-1:0] lw_addr_q;
  mpa_pkg::entry_t      mem [mpa_pkg::STORE_DEPTH];

  logic s_acc, s1_go, wr_en;

  logic [PB+HB+1:0] col_span, row_span, col_next, row_next;
  logic             fits_c, fits_r, last_c, last_r, last_ch;

  always_comb begin
    col_span = (PB+HB+2)'(({1'b0, pcol_q} + (PB+1)'(1)) * win_q);
    row_span = (PB+HB+2)'(({1'b0, prow_q} + (PB+1)'(1)) * win_q);
    col_next = col_span + (PB+HB+2)'(win_q);
    row_next = row_span + (PB+HB+2)'(win_q);
    fits_c   = col_span <= (PB+HB+2)'(width_q);
    fits_r   = row_span <= (PB+HB+2)'(height_q);
    last_c   = col_next > (PB+HB+2)'(width_q);
    last_r   = row_next > (PB+HB+2)'(height_q);
    last_ch  = ((CB+1)'(chan_q) + (CB+1)'(1)) == chans_q;
  end

  always_comb begin
    s0.sample     = $signed(s_axis_tdata);
    s0.first      = (cph_q == '0) && (rph_q == '0);
    s0.fits       = fits_c && fits_r;
    s0.prod       = s0.fits && ((HB+1)'(cph_q) + (HB+1)'(1) == win_q)
                    && ((HB+1)'(rph_q) + (HB+1)'(1) == win_q);
    s0.argmax     = {cph_q, rph_q};
    s0.addr       = {pcol_q[mpa_pkg::COL_BITS-1:0], chan_q};
    s0.pcol       = pcol_q;
    s0.prow       = prow_q;
    s0.chan       = chan_q;
    s0.last_img   = last_c && last_r && last_ch;
    s0.last_batch = last_c && last_r && last_ch
                    && ((IB+1)'(img_q) + (IB+1)'(1) >= (IB+1)'(batch_q));
  end

  assign s1_go         = s1_valid_q && (!s1_q.prod || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_go && s1_q.fits;

  always_comb begin
    old_ent = (lw_valid_q && (lw_addr_q == s1_q.addr)) ? lw_data_q : rd_q;
    if (s1_q.first) begin
      new_ent.value  = s1_q.sample;
      new_ent.argmax = '0;
    end else if ($signed(s1_q.sample) > $signed(old_ent.value)) begin
      new_ent.value  = s1_q.sample;
      new_ent.argmax = s1_q.argmax;
    end else begin
      new_ent = old_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_q.addr] <= new_ent;
    end
    if (s_acc) begin
      rd_q <= mem[s0.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= s0;
    end
    if (wr_en) begin
      lw_addr_q <= s1_q.addr;
      lw_data_q <= new_ent;
    end
    if (s1_go && s1_q.prod) begin
      out_q.ent        <= new_ent;
      out_q.pcol       <= s1_q.pcol;
      out_q.prow       <= s1_q.prow;
      out_q.chan       <= s1_q.chan;
      out_q.last_img   <= s1_q.last_img;
      out_q.last_batch <= s1_q.last_batch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
    end else begin
      if (s_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go && s1_q.prod) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= (PB+1)'(8);
      height_q <= (PB+1)'(8);
      chans_q  <= (CB+1)'(1);
      win_q    <= (HB+1)'(2);
      batch_q  <= IB'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpa_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_data_i[PB:0] == '0) width_q <= (PB+1)'(1);
          else if (cfg_data_i[PB:0] > (PB+1)'(mpa_pkg::MAX_WIDTH))
            width_q <= (PB+1)'(mpa_pkg::MAX_WIDTH);
          else width_q <= cfg_data_i[PB:0];
        end
        mpa_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg_data_i[PB:0] == '0) height_q <= (PB+1)'(1);
          else if (cfg_data_i[PB:0] > (PB+1)'(256)) height_q <= (PB+1)'(256);
          else height_q <= cfg_data_i[PB:0];
        end
        mpa_pkg::REG_CHANNEL_COUNT: begin
          if (cfg_data_i[CB:0] == '0) chans_q <= (CB+1)'(1);
          else if (cfg_data_i[CB:0] > (CB+1)'(mpa_pkg::MAX_CHANNELS))
            chans_q <= (CB+1)'(mpa_pkg::MAX_CHANNELS);
          else chans_q <= cfg_data_i[CB:0];
        end
        mpa_pkg::REG_WINDOW_SIZE: begin
          if (cfg_data_i[HB:0] == '0) win_q <= (HB+1)'(1);
          else if (cfg_data_i[HB:0] > (HB+1)'(16)) win_q <= (HB+1)'(16);
          else win_q <= cfg_data_i[HB:0];
        end
        mpa_pkg::REG_BATCH_COUNT: begin
          if (cfg_data_i[IB-1:0] == '0) batch_q <= IB'(1);
          else batch_q <= cfg_data_i[IB-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pcol_q <= '0;
      prow_q <= '0;
      chan_q <= '0;
      cph_q  <= '0;
      rph_q  <= '0;
      img_q  <= '0;
    end else if (s_acc) begin
      if ((CB+1)'(chan_q) + (CB+1)'(1) < chans_q) begin
        chan_q <= chan_q + CB'(1);
      end else begin
        chan_q <= '0;
        if ((PB+1)'(col_q) + (PB+1)'(1) < width_q) begin
          col_q <= col_q + PB'(1);
          if (fits_c) begin
            if ((HB+1)'(cph_q) + (HB+1)'(1) < win_q) begin
              cph_q <= cph_q + HB'(1);
            end else begin
              cph_q  <= '0;
              pcol_q <= pcol_q + PB'(1);
            end
          end
        end else begin
          col_q  <= '0;
          cph_q  <= '0;
          pcol_q <= '0;
          if ((PB+1)'(row_q) + (PB+1)'(1) < height_q) begin
            row_q <= row_q + PB'(1);
            if (fits_r) begin
              if ((HB+1)'(rph_q) + (HB+1)'(1) < win_q) begin
                rph_q <= rph_q + HB'(1);
              end else begin
                rph_q  <= '0;
                prow_q <= prow_q + PB'(1);
              end
            end
          end else begin
            row_q  <= '0;
            rph_q  <= '0;
            prow_q <= '0;
            if ((IB+1)'(img_q) + (IB+1)'(1) < (IB+1)'(batch_q)) begin
              img_q <= img_q + IB'(1);
            end else begin
              img_q <= '0;
            end
          end
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.chan, out_q.prow, out_q.pcol,
                          out_q.ent.argmax, out_q.ent.value};
  assign m_axis_tlast  = out_q.last_img;
  assign m_axis_tuser  = out_q.last_batch;

endmodule
